FILE: design/atbash_pattern_matcher_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the atbash pattern matcher checker
// Clocked on clk; the first two are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ATBASH_PATTERN_MATCHER_DEFINES_SVH
`define ATBASH_PATTERN_MATCHER_DEFINES_SVH

// same-cycle implication
`define APM_CHECK_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("apm check failed");

// next-cycle implication
`define APM_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("apm check failed");

// holds in the cycle after reset is applied
`define APM_CHECK_RESET(label, cons) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("apm reset check failed");

`endif

FILE: design/apm_pkg.sv
// ----------------------------------------------------------------------------
// apm_pkg
// Shared types, constants and helpers of the atbash pattern matcher.
// ----------------------------------------------------------------------------
package apm_pkg;

  localparam int MAX_PATTERN_DEF = 32;
  localparam int WIN_DEPTH       = 32;
  localparam int QDEPTH          = 4;

  localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
  localparam logic [7:0] CH_LZ    = 8'h7A;  // 'z'
  localparam logic [7:0] CH_UA    = 8'h41;  // 'A'
  localparam logic [7:0] CH_UZ    = 8'h5A;  // 'Z'
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  typedef enum logic [1:0] {
    K_WORD_END,
    K_WORD_CHAR,
    K_TEXT
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [7:0] image;
    logic       img_letter;
    logic       tilde;
  } q_entry_t;

  typedef struct packed {
    logic [15:0] start;
    logic [4:0]  len;
    logic        rev;
    logic        done;
  } res_t;

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= CH_LA && b <= CH_LZ) || (b >= CH_UA && b <= CH_UZ);
  endfunction

  function automatic logic [7:0] atbash(input logic [7:0] b);
    logic [7:0] r;
    r = CH_SPACE;
    if (b >= CH_LA && b <= CH_LZ) r = CH_LZ - (b - CH_LA);
    else if (b >= CH_UA && b <= CH_UZ) r = CH_UZ - (b - CH_UA);
    return r;
  endfunction

endpackage

FILE: design/apm_if.sv
// ----------------------------------------------------------------------------
// apm channel interfaces
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface apm_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;
  modport source (output valid, cmd, data_byte, input ready);
  modport sink   (input valid, cmd, data_byte, output ready);
endinterface

interface apm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] match_start;
  logic [4:0]  match_length;
  logic        reversed_hit;
  logic        text_done;
  logic        last_in_run;
  modport source (output valid, match_start, match_length, reversed_hit, text_done,
                  last_in_run, input ready);
  modport sink   (input valid, match_start, match_length, reversed_hit, text_done,
                  last_in_run, output ready);
endinterface

FILE: design/atbash_pattern_matcher.sv
// ----------------------------------------------------------------------------
// atbash_pattern_matcher
// Atbash word matcher: builds direct and reversed patterns from word bytes
// and reports matches found in the streamed text.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  din     | in  | cmd, data_byte
//  dout    | out | match_start, match_length, reversed_hit, text_done, last_in_run
//
//  Word bytes are taken by the back end in its idle state, with no resolve pass.
//  A text byte is loaded into the window, then takes one resolve step per
//  dropped position or match (up to 32), then a done word on tilde, then the flush.
//  apm_back's resolve sequencer runs these steps; a 4-word queue decouples input.
//  Synchronous active-high reset; no clearing pass.
//  A stalled dout holds the back end only when a result must move out.
// ----------------------------------------------------------------------------
module atbash_pattern_matcher #(
  parameter int MAX_PATTERN = apm_pkg::MAX_PATTERN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  apm_in_if.sink     din,
  apm_out_if.source  dout
);

  logic              push;
  logic              full;
  logic              q_valid;
  logic              pop;
  apm_pkg::q_entry_t entry;
  apm_pkg::q_entry_t q_head;

  apm_front u_front (
    .din   (din),
    .full  (full),
    .push  (push),
    .entry (entry)
  );

  apm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (entry),
    .pop        (pop),
    .valid      (q_valid),
    .full       (full),
    .head       (q_head)
  );

  apm_back #(.MAX_PATTERN(MAX_PATTERN)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_head  (q_head),
    .pop     (pop),
    .dout    (dout)
  );

endmodule

FILE: design/apm_front.sv
// ----------------------------------------------------------------------------
// apm_front
// Accepts input words, classifies them and precomputes the atbash image.
// ----------------------------------------------------------------------------
module apm_front (
  apm_in_if.sink            din,
  input  logic              full,
  output logic              push,
  output apm_pkg::q_entry_t entry
);

  logic is_ws;

  assign is_ws = (din.data_byte == apm_pkg::CH_SPACE) ||
                 (din.data_byte == apm_pkg::CH_TAB) ||
                 (din.data_byte == apm_pkg::CH_NL);

  assign din.ready = !full;
  assign push      = din.valid && !full;

  always_comb begin
    if (din.cmd) entry.kind = apm_pkg::K_TEXT;
    else if (is_ws) entry.kind = apm_pkg::K_WORD_END;
    else entry.kind = apm_pkg::K_WORD_CHAR;
    entry.data_byte  = din.data_byte;
    entry.image      = apm_pkg::atbash(din.data_byte);
    entry.img_letter = apm_pkg::is_letter(din.data_byte);
    entry.tilde      = (din.data_byte == apm_pkg::CH_TILDE);
  end

endmodule

FILE: design/apm_queue.sv
// ----------------------------------------------------------------------------
// apm_queue
// Short FIFO between the classifier and the execution back end.
// ----------------------------------------------------------------------------
module apm_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  apm_pkg::q_entry_t push_entry,
  input  logic              pop,
  output logic              valid,
  output logic              full,
  output apm_pkg::q_entry_t head
);

  localparam int PtrW = $clog2(apm_pkg::QDEPTH);
  localparam int CntW = $clog2(apm_pkg::QDEPTH + 1);

  apm_pkg::q_entry_t mem [apm_pkg::QDEPTH];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;
  logic              do_push;
  logic              do_pop;

  assign valid   = (count != '0);
  assign full    = (count == CntW'(apm_pkg::QDEPTH));
  assign head    = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (!do_push && do_pop) count <= count - 1'b1;
    end
  end

endmodule

FILE: design/apm_back.sv
// ----------------------------------------------------------------------------
// apm_back
// Builds the patterns, keeps the text window and resolves scan positions,
// one resolve step per cycle unless a match stalls; a held result marks the last.
// ----------------------------------------------------------------------------
module apm_back #(
  parameter int MAX_PATTERN = apm_pkg::MAX_PATTERN_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  apm_pkg::q_entry_t q_head,
  output logic              pop,
  apm_out_if.source         dout
);

  localparam int         PatCap  = (MAX_PATTERN - 1 < 31) ? MAX_PATTERN - 1 : 31;
  localparam logic [4:0] PatCapL = 5'(PatCap);
  localparam int         WinD    = apm_pkg::WIN_DEPTH;
  localparam logic [5:0] WinDL   = 6'(WinD);
  localparam logic [4:0] MaxRes  = 5'd16;

  typedef enum logic [1:0] {S_IDLE, S_RESOLVE, S_DONE, S_FLUSH} state_t;
  typedef enum logic [1:0] {A_DROP, A_WAIT, A_MATCH} act_t;

  state_t        state;
  logic [7:0]    dpat [PatCap];
  logic [7:0]    rpat [PatCap];
  logic [4:0]    dlen;
  logic [4:0]    rlen;
  logic          wc;
  logic [7:0]    win [WinD];
  logic [5:0]    cnt;
  logic [15:0]   tpos;
  logic [15:0]   nep;
  logic          skip;
  logic [4:0]    nres;
  logic          tilde_f;
  logic [15:0]   done_pos;
  apm_pkg::res_t held;
  logic          held_valid;
  apm_pkg::res_t out_r;
  logic          out_last;
  logic          out_valid;

  // resolve step
  logic          use_d;
  logic          use_r;
  logic [5:0]    plen6;
  logic [5:0]    avail6;
  logic          bad;
  act_t          act;
  logic [5:0]    m6;
  logic [7:0]    win_sh [WinD];
  logic [16:0]   nep_sum;
  logic [15:0]   nep_adv;
  logic          loop_end;
  logic          out_free;
  logic          can_hold;
  logic          emit_req;
  apm_pkg::res_t emit_res;
  logic          emit_go;
  logic          flush_go;

  always_comb begin
    logic [7:0] pb;
    logic [6:0] sel;
    use_d  = (dlen != '0) && (win[0] == dpat[0]);
    use_r  = !use_d && (rlen != '0) && (win[0] == rpat[0]);
    plen6  = {1'b0, (use_d ? dlen : rlen)};
    avail6 = (cnt < plen6) ? cnt : plen6;
    bad    = 1'b0;
    for (int i = 0; i < PatCap; i++) begin
      pb = use_d ? dpat[i] : rpat[i];
      if (6'(i) < avail6 && win[i] != pb) bad = 1'b1;
    end
    if (!use_d && !use_r) act = A_DROP;
    else if (bad) act = A_DROP;
    else if (cnt < plen6) act = A_WAIT;
    else act = A_MATCH;
    if (act == A_MATCH) m6 = (cnt > plen6) ? plen6 + 6'd1 : plen6;
    else m6 = 6'd1;
    for (int i = 0; i < WinD; i++) begin
      sel = 7'(i) + {1'b0, m6};
      win_sh[i] = (sel < 7'(WinD)) ? win[sel[4:0]] : 8'h00;
    end
    nep_sum = {1'b0, nep} + {11'd0, m6};
    nep_adv = nep_sum[16] ? 16'hFFFF : nep_sum[15:0];
  end

  assign loop_end = (cnt == '0) || (nres == MaxRes) || (act == A_WAIT);
  assign out_free = !out_valid || dout.ready;
  assign can_hold = !held_valid || out_free;

  always_comb begin
    emit_req = 1'b0;
    emit_res = '{start: nep, len: plen6[4:0], rev: use_r, done: 1'b0};
    if (state == S_RESOLVE && !loop_end && act == A_MATCH) emit_req = 1'b1;
    if (state == S_DONE) begin
      emit_req = 1'b1;
      emit_res = '{start: done_pos, len: 5'd0, rev: 1'b0, done: 1'b1};
    end
  end

  assign emit_go  = emit_req && can_hold;
  assign flush_go = (state == S_FLUSH) && held_valid && out_free;
  assign pop      = (state == S_IDLE) && q_valid;

  // pattern build
  always_ff @(posedge clk) begin
    logic [4:0] dl;
    dl = wc ? 5'd0 : dlen;
    if (pop && q_head.kind == apm_pkg::K_WORD_CHAR && dl < PatCapL) begin
      for (int i = 0; i < PatCap; i++)
        if (5'(i) == dl) dpat[i] <= q_head.image;
      if (q_head.img_letter) begin
        for (int i = PatCap - 1; i > 0; i--) rpat[i] <= rpat[i-1];
        rpat[0] <= q_head.image;
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [4:0] dl;
    logic [4:0] rl;
    dl = wc ? 5'd0 : dlen;
    rl = wc ? 5'd0 : rlen;
    if (rst) begin
      state      <= S_IDLE;
      dlen       <= '0;
      rlen       <= '0;
      wc         <= 1'b0;
      cnt        <= '0;
      tpos       <= '0;
      nep        <= '0;
      skip       <= 1'b0;
      nres       <= '0;
      tilde_f    <= 1'b0;
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
      for (int i = 0; i < WinD; i++) win[i] <= 8'h00;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            unique case (q_head.kind)
              apm_pkg::K_WORD_END: begin
                dlen <= dl;
                rlen <= rl;
                wc   <= 1'b1;
              end
              apm_pkg::K_WORD_CHAR: begin
                wc <= 1'b0;
                if (dl < PatCapL) begin
                  dlen <= dl + 5'd1;
                  rlen <= q_head.img_letter ? rl + 5'd1 : rl;
                end else begin
                  dlen <= dl;
                  rlen <= rl;
                end
              end
              default: begin
                done_pos <= tpos;
                if (tpos != 16'hFFFF) tpos <= tpos + 16'd1;
                tilde_f <= q_head.tilde;
                nres    <= '0;
                if (skip) begin
                  skip <= 1'b0;
                  if (nep != 16'hFFFF) nep <= nep + 16'd1;
                end else if (cnt < WinDL) begin
                  win[cnt[4:0]] <= q_head.data_byte;
                  cnt <= cnt + 6'd1;
                end
                state <= S_RESOLVE;
              end
            endcase
          end
        end
        S_RESOLVE: begin
          if (loop_end) begin
            state <= tilde_f ? S_DONE : S_FLUSH;
          end else if (act == A_DROP || emit_go) begin
            win <= win_sh;
            cnt <= cnt - m6;
            nep <= nep_adv;
            if (act == A_MATCH) begin
              nres <= nres + 5'd1;
              if (cnt == plen6) skip <= 1'b1;
            end
          end
        end
        S_DONE: begin
          if (emit_go) begin
            cnt   <= '0;
            tpos  <= '0;
            nep   <= '0;
            skip  <= 1'b0;
            state <= S_FLUSH;
          end
        end
        default: begin
          if (!held_valid || flush_go) state <= S_IDLE;
        end
      endcase

      if (emit_go) begin
        held       <= emit_res;
        held_valid <= 1'b1;
        if (held_valid) begin
          out_r     <= held;
          out_last  <= 1'b0;
          out_valid <= 1'b1;
        end else if (dout.ready) begin
          out_valid <= 1'b0;
        end
      end else if (flush_go) begin
        out_r      <= held;
        out_last   <= 1'b1;
        out_valid  <= 1'b1;
        held_valid <= 1'b0;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign dout.valid        = out_valid;
  assign dout.match_start  = out_r.start;
  assign dout.match_length = out_r.len;
  assign dout.reversed_hit = out_r.rev;
  assign dout.text_done    = out_r.done;
  assign dout.last_in_run  = out_last;

endmodule

FILE: design/apm_checker.sv
// ----------------------------------------------------------------------------
// apm_checker
// Port-level checks of the atbash pattern matcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "atbash_pattern_matcher_defines.svh"

module apm_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] match_start,
  input logic [4:0]  match_length,
  input logic        reversed_hit,
  input logic        text_done,
  input logic        last_in_run
);

  `APM_CHECK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(match_start) && $stable(match_length) && $stable(text_done) && $stable(last_in_run))
  `APM_CHECK_SAME(a_done_word, out_valid && text_done, match_length == 5'd0 && !reversed_hit && last_in_run)
  `APM_CHECK_SAME(a_match_len, out_valid && !text_done, match_length != 5'd0)
  `APM_CHECK_RESET(a_reset_idle, !out_valid)

endmodule

bind atbash_pattern_matcher apm_checker u_apm_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (dout.valid),
  .out_ready    (dout.ready),
  .match_start  (dout.match_start),
  .match_length (dout.match_length),
  .reversed_hit (dout.reversed_hit),
  .text_done    (dout.text_done),
  .last_in_run  (dout.last_in_run)
);
